[rtl/btb_pkg.sv]
// shared types, constants and helper functions of the bilinear tint blend pixel shader
`timescale 1ns / 1ps
`default_nettype none

package btb_pkg;

  // default fraction precision of the bilinear filter
  localparam int unsigned FRAC_BITS_DEF = 8;

  // configuration register index width
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [31:0] pixel_t;
  typedef logic [7:0]  frac_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CfgFillColor    = 2'd0,
    CfgTexturedMode = 2'd1,
    CfgBlendEnable  = 2'd2
  } cfg_idx_e;

  localparam pixel_t PIXEL_ONES  = 32'hFFFF_FFFF;
  localparam logic [7:0] CHAN_MAX = 8'hFF;

  // fill colour is held as aabbggrr, the datapath wants aarrggbb
  function automatic pixel_t abgr_to_argb(input pixel_t c);
    return {c[31:24], c[7:0], c[15:8], c[23:16]};
  endfunction

  // floor(x / 255) for x up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return t[15:8];
  endfunction

endpackage

`default_nettype wire

[rtl/btb_pix_in_if.sv]
// input item channel: four texels, sample fractions and destination pixel
`timescale 1ns / 1ps
`default_nettype none

interface btb_pix_in_if
  import btb_pkg::*;
();
  logic   valid;
  logic   ready;
  pixel_t texel_00;
  pixel_t texel_10;
  pixel_t texel_01;
  pixel_t texel_11;
  frac_t  frac_x;
  frac_t  frac_y;
  pixel_t dest_pixel;

  modport source (
    output valid, texel_00, texel_10, texel_01, texel_11, frac_x, frac_y, dest_pixel,
    input  ready
  );

  modport sink (
    input  valid, texel_00, texel_10, texel_01, texel_11, frac_x, frac_y, dest_pixel,
    output ready
  );
endinterface

`default_nettype wire

[rtl/btb_pix_out_if.sv]
// result item channel: shaded pixel
`timescale 1ns / 1ps
`default_nettype none

interface btb_pix_out_if
  import btb_pkg::*;
();
  logic   valid;
  logic   ready;
  pixel_t result_pixel;

  modport source (
    output valid, result_pixel,
    input  ready
  );

  modport sink (
    input  valid, result_pixel,
    output ready
  );
endinterface

`default_nettype wire

[rtl/btb_cfg_if.sv]
// configuration write channel: register index and write data
`timescale 1ns / 1ps
`default_nettype none

interface btb_cfg_if
  import btb_pkg::*;
();
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  pixel_t   data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

`default_nettype wire

[rtl/bilinear_tint_blend_pixel.sv]
// top level: pipelined bilinear filter, tint and source-over blend of one pixel per clock when not stalled
//
//   channel   | dir | handshake     | payload
//   ----------+-----+---------------+----------------------------------------------
//   cfg_i     | in  | valid / ready | index (0 fill colour, 1 textured, 2 blend), data
//   pix_i     | in  | valid / ready | texel_00/10/01/11, frac_x, frac_y, dest_pixel
//   pix_o     | out | valid / ready | result_pixel
//
// seven register stages, one item per clock sustained while pix_o.ready stays high; the
// stage count is set by the filter multiplies, the add tree, and the two divide-by-255
// steps (tint and blend)
// each stage advances when it is empty or the stage after it advances, so
// bubbles close up and the input keeps taking items while a result waits, until the stages fill
// rst_ni clears the stage valid bits and loads the configuration register reset values
// configuration writes are always taken (cfg_i.ready tied high)
`timescale 1ns / 1ps
`default_nettype none

module bilinear_tint_blend_pixel
  import btb_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  btb_cfg_if.sink        cfg_i,
  btb_pix_in_if.sink     pix_i,
  btb_pix_out_if.source  pix_o
);

  // widths that follow from the fraction precision
  localparam int unsigned SCL_W = FRAC_BITS + 1;      // 2^F and its complements
  localparam int unsigned WGT_W = 2 * FRAC_BITS + 1;  // bilinear weights, max 2^(2F)
  localparam int unsigned PRD_W = WGT_W + 8;          // channel times weight
  localparam int unsigned SUM_W = PRD_W + 1;          // four products plus rounding
  localparam int unsigned NSTG  = 7;

  // ------------------------------------------------------------------
  // configuration registers
  // ------------------------------------------------------------------
  pixel_t fill_color_q;
  logic   textured_q;
  logic   blend_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_color_q <= PIXEL_ONES;
      textured_q   <= 1'b0;
      blend_q      <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgFillColor:    fill_color_q <= cfg_i.data;
        CfgTexturedMode: textured_q   <= cfg_i.data[0];
        CfgBlendEnable:  blend_q      <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  pixel_t color;
  logic   tint_pass;

  assign color     = abgr_to_argb(fill_color_q);
  // all-ones tint leaves the texel untouched
  assign tint_pass = (fill_color_q == PIXEL_ONES);

  // ------------------------------------------------------------------
  // stage control: valid bits and per-stage advance
  // ------------------------------------------------------------------
  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !vld_q[NSTG-1] || pix_o.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign pix_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= pix_i.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // stage 1: bilinear weights from the fractions
  // ------------------------------------------------------------------
  logic [FRAC_BITS+7:0] fx_ext, fy_ext;
  logic [FRAC_BITS-1:0] tx, ty;
  logic [SCL_W-1:0]     one_s, tx_w, ty_w, ix, iy;
  logic [2*SCL_W-1:0]   wp00, wp10, wp01, wp11;  // raw products, 2F+2 bits

  always_comb begin
    // fraction bits at or above FRAC_BITS are dropped
    fx_ext = (FRAC_BITS + 8)'(pix_i.frac_x);
    fy_ext = (FRAC_BITS + 8)'(pix_i.frac_y);
    tx     = fx_ext[FRAC_BITS-1:0];
    ty     = fy_ext[FRAC_BITS-1:0];
    one_s  = {1'b1, {FRAC_BITS{1'b0}}};
    tx_w   = {1'b0, tx};
    ty_w   = {1'b0, ty};
    ix     = one_s - tx_w;
    iy     = one_s - ty_w;
    wp00   = (2 * SCL_W)'(ix) * (2 * SCL_W)'(iy);
    wp10   = (2 * SCL_W)'(tx_w) * (2 * SCL_W)'(iy);
    wp01   = (2 * SCL_W)'(ix) * (2 * SCL_W)'(ty_w);
    wp11   = (2 * SCL_W)'(tx_w) * (2 * SCL_W)'(ty_w);
  end

  pixel_t           tex1_q [4];
  logic [WGT_W-1:0] w1_q   [4];
  pixel_t           dst1_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      tex1_q[0] <= pix_i.texel_00;
      tex1_q[1] <= pix_i.texel_10;
      tex1_q[2] <= pix_i.texel_01;
      tex1_q[3] <= pix_i.texel_11;
      w1_q[0]   <= wp00[WGT_W-1:0];
      w1_q[1]   <= wp10[WGT_W-1:0];
      w1_q[2]   <= wp01[WGT_W-1:0];
      w1_q[3]   <= wp11[WGT_W-1:0];
      dst1_q    <= pix_i.dest_pixel;
    end
  end

  // ------------------------------------------------------------------
  // stage 2: channel times weight, sixteen products
  // ------------------------------------------------------------------
  logic [PRD_W-1:0] prd2_d [4][4];
  logic [PRD_W-1:0] prd2_q [4][4];
  pixel_t           dst2_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int t = 0; t < 4; t++) begin
        prd2_d[c][t] = PRD_W'(tex1_q[t][8*c +: 8]) * PRD_W'(w1_q[t]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      prd2_q <= prd2_d;
      dst2_q <= dst1_q;
    end
  end

  // ------------------------------------------------------------------
  // stage 3: sum, round half up, scale back to 8 bits
  // ------------------------------------------------------------------
  logic [SUM_W-1:0] half_s;
  logic [SUM_W-1:0] sum3   [4];
  logic [9:0]       rnd3   [4];
  pixel_t           bil3_d;
  pixel_t           bil3_q;
  pixel_t           dst3_q;

  always_comb begin
    half_s = SUM_W'(1) << (2 * FRAC_BITS - 1);
    for (int c = 0; c < 4; c++) begin
      sum3[c] = SUM_W'(prd2_q[c][0]) + SUM_W'(prd2_q[c][1])
              + SUM_W'(prd2_q[c][2]) + SUM_W'(prd2_q[c][3]) + half_s;
      rnd3[c] = sum3[c][SUM_W-1:2*FRAC_BITS];
      bil3_d[8*c +: 8] = (rnd3[c] > 10'd255) ? CHAN_MAX : rnd3[c][7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      bil3_q <= bil3_d;
      dst3_q <= dst2_q;
    end
  end

  // ------------------------------------------------------------------
  // stage 4: tint products
  // ------------------------------------------------------------------
  logic [15:0] tprd4_d [4];
  logic [15:0] tprd4_q [4];
  pixel_t      tex4_q;
  pixel_t      dst4_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      tprd4_d[c] = 16'(bil3_q[8*c +: 8]) * 16'(color[8*c +: 8]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      tprd4_q <= tprd4_d;
      tex4_q  <= bil3_q;
      dst4_q  <= dst3_q;
    end
  end

  // ------------------------------------------------------------------
  // stage 5: divide tint products by 255, pick the source
  // ------------------------------------------------------------------
  pixel_t tint5;
  pixel_t src5_d;
  pixel_t src5_q;
  pixel_t dst5_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      tint5[8*c +: 8] = div255(tprd4_q[c]);
    end
    if (!textured_q) begin
      src5_d = color;
    end else if (tint_pass) begin
      src5_d = tex4_q;
    end else begin
      src5_d = tint5;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      src5_q <= src5_d;
      dst5_q <= dst4_q;
    end
  end

  // ------------------------------------------------------------------
  // stage 6: blend products s*sa + d*(255-sa) for the colour channels
  // ------------------------------------------------------------------
  logic [7:0]  sa5, isa5;
  logic [15:0] bs6_a [3];
  logic [15:0] bs6_b [3];
  logic [15:0] bsum6_d [3];
  logic [15:0] bsum6_q [3];
  pixel_t      src6_q;
  pixel_t      dst6_q;

  always_comb begin
    sa5  = src5_q[31:24];
    isa5 = CHAN_MAX - sa5;
    for (int c = 0; c < 3; c++) begin
      bs6_a[c]   = 16'(src5_q[8*c +: 8]) * 16'(sa5);
      bs6_b[c]   = 16'(dst5_q[8*c +: 8]) * 16'(isa5);
      bsum6_d[c] = bs6_a[c] + bs6_b[c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      bsum6_q <= bsum6_d;
      src6_q  <= src5_q;
      dst6_q  <= dst5_q;
    end
  end

  // ------------------------------------------------------------------
  // stage 7: divide by 255, alpha special cases, output register
  // ------------------------------------------------------------------
  pixel_t blend7;
  pixel_t res7_d;
  pixel_t res7_q;

  always_comb begin
    blend7[31:24] = CHAN_MAX;
    for (int c = 0; c < 3; c++) begin
      blend7[8*c +: 8] = div255(bsum6_q[c]);
    end
    if (!blend_q || src6_q[31:24] == CHAN_MAX) begin
      res7_d = src6_q;
    end else if (src6_q[31:24] == 8'd0) begin
      res7_d = dst6_q;
    end else begin
      res7_d = blend7;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      res7_q <= res7_d;
    end
  end

  assign pix_o.valid        = vld_q[NSTG-1];
  assign pix_o.result_pixel = res7_q;

`ifndef SYNTHESIS
  // input only stalls when every stage holds an item
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_i.ready |-> (&vld_q))
    else $error("input stalled with an empty stage");

  // an item in the last stage but one moves to the output when it advances
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en[NSTG-1] && vld_q[NSTG-2]) |=> pix_o.valid)
    else $error("item lost between the last two stages");

  // blending a source that is not fully transparent yields opaque alpha
  a_blend_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en[NSTG-1] && vld_q[NSTG-2] && blend_q && src6_q[31:24] != 8'd0)
      |=> (pix_o.result_pixel[31:24] == CHAN_MAX))
    else $error("blended result alpha is not opaque");

  // solid fill without blending gives the reordered fill colour
  a_solid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_o.valid && !textured_q && !blend_q)
      |-> (pix_o.result_pixel == abgr_to_argb(fill_color_q)))
    else $error("solid fill result differs from fill colour");
`endif

endmodule

`default_nettype wire
